// ===== rtl/assert_macros.svh =====
// Assertion macros for the keyed linked list table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define KLLT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("kllt assertion failed");
`define KLLT_ASSERT_NODIS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("kllt assertion failed");
`else
`define KLLT_ASSERT(lbl, clk, rstn, prop)
`define KLLT_ASSERT_NODIS(lbl, clk, prop)
`endif

`endif

// ===== rtl/kllt_pkg.sv =====
// Shared types and constants for the keyed linked list table
package kllt_pkg;

  localparam int unsigned ElemW = 10;
  localparam int unsigned ValW  = 8;

  typedef enum logic {
    CMD_SET  = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_UNLINK,
    S_PUSH1,
    S_PUSH2,
    S_OUT
  } state_e;

endpackage

// ===== rtl/keyed_linked_list_table_top.sv =====
// Keyed linked list table: value, link and head memories under one sequencer
//
// After reset the block runs a clearing pass over max(ELEMENT_COUNT, VALUE_COUNT)
// addresses (1024 by default) and is not ready meanwhile. It then handles one
// command at a time: a read, a set that names the null or an out-of-range
// element or an out-of-range value, or a set that leaves the value unchanged
// goes from read and evaluate straight to output; a set that changes the value
// adds an unlink step for a nonempty old list and a step that fixes the old
// head of a nonempty new list after its push. The output step waits while the
// previous result still waits. The extra steps come from the single write
// port of each link memory and the registered read of all four memories. The
// output register lets a new command be taken while the previous result waits.
`include "assert_macros.svh"

module keyed_linked_list_table_top
  import kllt_pkg::*;
#(
  parameter int unsigned ELEMENT_COUNT = 1024,
  parameter int unsigned VALUE_COUNT   = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_i,
  input  logic [ElemW-1:0] element_i,
  input  logic [ValW-1:0]  value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             changed_o,
  output logic [ValW-1:0]  elem_value_o,
  output logic [ElemW-1:0] elem_next_o,
  output logic [ElemW-1:0] first_of_value_o,
  output logic             bad_element_o
);

  localparam int unsigned AW       = $clog2(ELEMENT_COUNT);
  localparam int unsigned VAW      = $clog2(VALUE_COUNT);
  localparam int unsigned ClrDepth = (ELEMENT_COUNT > VALUE_COUNT) ? ELEMENT_COUNT
                                                                   : VALUE_COUNT;
  localparam int unsigned CW       = $clog2(ClrDepth);

  logic [ValW-1:0]  val_mem  [ELEMENT_COUNT];
  logic [ElemW-1:0] prev_mem [ELEMENT_COUNT];
  logic [ElemW-1:0] next_mem [ELEMENT_COUNT];
  logic [ElemW-1:0] head_mem [VALUE_COUNT];

  state_e           state_q, state_d;
  logic [CW-1:0]    clr_q, clr_d;
  cmd_e             cmd_q;
  logic [ElemW-1:0] elem_q;
  logic [ValW-1:0]  val_q;
  logic             chg_q, chg_d;

  logic [ValW-1:0]  old_rd_q;
  logic [ElemW-1:0] prev_rd_q, next_rd_q, head_rd_q;
  logic             rd_en;

  logic             val_we, prev_we, next_we, head_we;
  logic [AW-1:0]    val_wa, prev_wa, next_wa;
  logic [VAW-1:0]   head_wa;
  logic [ValW-1:0]  val_wd;
  logic [ElemW-1:0] prev_wd, next_wd, head_wd;

  logic             e_ok, v_ok, v_nz, h_nz;
  logic             clr_elem, clr_val;

  logic             out_valid_q;
  logic             changed_q, bad_q;
  logic [ValW-1:0]  ev_q;
  logic [ElemW-1:0] en_q, fv_q;
  logic             out_load;
  logic             changed_d, bad_d;
  logic [ValW-1:0]  ev_d;
  logic [ElemW-1:0] en_d, fv_d;

  assign e_ok     = 32'(elem_q) < ELEMENT_COUNT;
  assign v_ok     = 32'(val_q) < VALUE_COUNT;
  assign v_nz     = val_q != '0;
  assign h_nz     = head_rd_q != '0;
  assign clr_elem = 32'(clr_q) < ELEMENT_COUNT;
  assign clr_val  = 32'(clr_q) < VALUE_COUNT;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign changed_o        = changed_q;
  assign elem_value_o     = ev_q;
  assign elem_next_o      = en_q;
  assign first_of_value_o = fv_q;
  assign bad_element_o    = bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      chg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      chg_q   <= chg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= cmd_e'(cmd_i);
      elem_q <= element_i;
      val_q  <= value_i;
    end
  end

  // memories: one write and one registered read each per cycle
  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    if (rd_en) old_rd_q <= val_mem[AW'(elem_q)];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (rd_en) prev_rd_q <= prev_mem[AW'(elem_q)];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (rd_en) next_rd_q <= next_mem[AW'(elem_q)];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (rd_en) head_rd_q <= head_mem[VAW'(val_q)];
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    chg_d   = chg_q;
    rd_en   = 1'b0;
    val_we  = 1'b0;
    prev_we = 1'b0;
    next_we = 1'b0;
    head_we = 1'b0;
    val_wa  = AW'(elem_q);
    prev_wa = AW'(elem_q);
    next_wa = AW'(elem_q);
    head_wa = VAW'(val_q);
    val_wd  = '0;
    prev_wd = '0;
    next_wd = '0;
    head_wd = '0;
    out_load = 1'b0;

    case (state_q)
      S_CLEAR: begin
        val_we  = clr_elem;
        prev_we = clr_elem;
        next_we = clr_elem;
        head_we = clr_val;
        val_wa  = AW'(clr_q);
        prev_wa = AW'(clr_q);
        next_wa = AW'(clr_q);
        head_wa = VAW'(clr_q);
        clr_d   = clr_q + 1'b1;
        if (clr_q == CW'(ClrDepth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        chg_d = (cmd_q == CMD_SET) && (elem_q != '0) && e_ok && v_ok
                && (old_rd_q != val_q);
        if (!chg_d) begin
          state_d = S_OUT;
        end else if (old_rd_q != '0) begin
          state_d = S_UNLINK;
        end else begin
          state_d = S_PUSH1;
        end
      end
      S_UNLINK: begin
        if (prev_rd_q != '0) begin
          next_we = 1'b1;
          next_wa = AW'(prev_rd_q);
          next_wd = next_rd_q;
        end else begin
          head_we = 1'b1;
          head_wa = VAW'(old_rd_q);
          head_wd = next_rd_q;
        end
        if (next_rd_q != '0) begin
          prev_we = 1'b1;
          prev_wa = AW'(next_rd_q);
          prev_wd = prev_rd_q;
        end
        state_d = S_PUSH1;
      end
      S_PUSH1: begin
        val_we  = 1'b1;
        val_wd  = val_q;
        prev_we = 1'b1;
        next_we = 1'b1;
        next_wd = v_nz ? head_rd_q : '0;
        head_we = v_nz;
        head_wd = elem_q;
        state_d = (v_nz && h_nz) ? S_PUSH2 : S_OUT;
      end
      S_PUSH2: begin
        prev_we = 1'b1;
        prev_wa = AW'(head_rd_q);
        prev_wd = elem_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (chg_q) begin
      changed_d = 1'b1;
      bad_d     = 1'b0;
      ev_d      = val_q;
      en_d      = v_nz ? head_rd_q : '0;
      fv_d      = v_nz ? elem_q : '0;
    end else begin
      changed_d = 1'b0;
      bad_d     = (cmd_q == CMD_SET) && (elem_q == '0);
      ev_d      = e_ok ? old_rd_q : '0;
      en_d      = e_ok ? next_rd_q : '0;
      fv_d      = (v_ok && v_nz) ? head_rd_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      changed_q <= changed_d;
      bad_q     <= bad_d;
      ev_q      <= ev_d;
      en_q      <= en_d;
      fv_q      <= fv_d;
    end
  end

  `KLLT_ASSERT(a_chg_not_bad, clk_i, rst_ni, out_valid_o |-> !(changed_o && bad_element_o))
  `KLLT_ASSERT(a_removed_empty, clk_i, rst_ni, (out_valid_o && changed_o && elem_value_o == '0) |-> (elem_next_o == '0 && first_of_value_o == '0))
  `KLLT_ASSERT(a_accept_starts, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> state_q == S_RD)
  `KLLT_ASSERT_NODIS(a_no_accept_clear, clk_i, (state_q == S_CLEAR) |-> !in_ready_o)

endmodule

// ===== verif/keyed_linked_list_table_checker.sv =====
// Checker for the keyed linked list table: predicts each result and compares it
`timescale 1ns / 100ps

module keyed_linked_list_table_checker
  import kllt_pkg::*;
#(
  parameter int unsigned ELEMENT_COUNT = 1024,
  parameter int unsigned VALUE_COUNT   = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             cmd_i,
  input  logic [ElemW-1:0] element_i,
  input  logic [ValW-1:0]  value_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic             changed_i,
  input  logic [ValW-1:0]  elem_value_i,
  input  logic [ElemW-1:0] elem_next_i,
  input  logic [ElemW-1:0] first_of_value_i,
  input  logic             bad_element_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic             changed;
    logic [ValW-1:0]  elem_value;
    logic [ElemW-1:0] elem_next;
    logic [ElemW-1:0] first_of_value;
    logic             bad_element;
  } table_result_t;

  logic [ValW-1:0]  value_mem [ELEMENT_COUNT];
  logic [ElemW-1:0] prev_mem  [ELEMENT_COUNT];
  logic [ElemW-1:0] next_mem  [ELEMENT_COUNT];
  logic [ElemW-1:0] head_mem  [VALUE_COUNT];

  table_result_t expected_q[$];
  int            fail_count;
  int            pending_count;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_count;

  function automatic table_result_t apply_command(input cmd_e             cmd,
                                                  input logic [ElemW-1:0] elem,
                                                  input logic [ValW-1:0]  val);
    table_result_t r;
    int unsigned   e, v, prior, p, n, h;
    bit            elem_in, val_in;
    e       = elem;
    v       = val;
    elem_in = e < ELEMENT_COUNT;
    val_in  = v < VALUE_COUNT;
    r       = '0;
    if (cmd == CMD_SET) begin
      if (e == 0) begin
        r.bad_element = 1'b1;
      end else if (elem_in && val_in) begin
        prior = value_mem[e];
        if (prior != v) begin
          // unlink from the old list, repairing neighbors or head
          if (prior != 0) begin
            p = prev_mem[e];
            n = next_mem[e];
            if (p != 0 && p < ELEMENT_COUNT) begin
              next_mem[p] = ElemW'(n);
            end else if (p == 0 && prior < VALUE_COUNT) begin
              head_mem[prior] = ElemW'(n);
            end
            if (n != 0 && n < ELEMENT_COUNT) begin
              prev_mem[n] = ElemW'(p);
            end
            prev_mem[e] = '0;
            next_mem[e] = '0;
          end
          value_mem[e] = ValW'(v);
          // push at head of the new list
          if (v != 0) begin
            h = head_mem[v];
            if (h != 0 && h < ELEMENT_COUNT) begin
              prev_mem[h] = ElemW'(e);
              next_mem[e] = ElemW'(h);
            end else begin
              next_mem[e] = '0;
            end
            head_mem[v] = ElemW'(e);
            prev_mem[e] = '0;
          end
          r.changed = 1'b1;
        end
      end
    end
    if (elem_in) begin
      r.elem_value = value_mem[e];
      r.elem_next  = next_mem[e];
    end
    if (val_in && v != 0) begin
      r.first_of_value = head_mem[v];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < ELEMENT_COUNT; i++) begin
        value_mem[i] = '0;
        prev_mem[i]  = '0;
        next_mem[i]  = '0;
      end
      for (int i = 0; i < VALUE_COUNT; i++) begin
        head_mem[i] = '0;
      end
      expected_q.delete();
      fail_count    = 0;
      pending_count = 0;
    end else begin
      // results first: a result never belongs to a command taken in the same cycle
      if (out_valid_i && out_ready_i) begin
        got = '{changed_i, elem_value_i, elem_next_i, first_of_value_i, bad_element_i};
        if (expected_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: unexpected result transfer: changed=%0d value=%0d next=%0d",
                     $time, got.changed, got.elem_value, got.elem_next);
          end
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch: expected changed=%0d value=%0d next=%0d first=%0d bad=%0d",
                       $time, want.changed, want.elem_value, want.elem_next,
                       want.first_of_value, want.bad_element);
              $display("%0t:           actual   changed=%0d value=%0d next=%0d first=%0d bad=%0d",
                       $time, got.changed, got.elem_value, got.elem_next,
                       got.first_of_value, got.bad_element);
            end
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(apply_command(cmd_e'(cmd_i), element_i, value_i));
      end
      pending_count = expected_q.size();
    end
  end

endmodule

// ===== verif/keyed_linked_list_table_top_tb.sv =====
// Testbench top for the keyed linked list table: stimulus, idling and verdict
`timescale 1ns / 100ps

module keyed_linked_list_table_top_tb
  import kllt_pkg::*;
();

  localparam int unsigned RandomItems = 1450;
  localparam int unsigned QuietFrom   = 1300;
  localparam int unsigned DrainAt     = 700;
  localparam int unsigned CycleLimit  = 400000;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             cmd_i;
  logic [ElemW-1:0] element_i;
  logic [ValW-1:0]  value_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             changed_o;
  logic [ValW-1:0]  elem_value_o;
  logic [ElemW-1:0] elem_next_o;
  logic [ElemW-1:0] first_of_value_o;
  logic             bad_element_o;

  int          fail_count;
  int          pending_count;
  bit          quiet;
  int unsigned cycle_count;

  keyed_linked_list_table_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .element_i        (element_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .changed_o        (changed_o),
    .elem_value_o     (elem_value_o),
    .elem_next_o      (elem_next_o),
    .first_of_value_o (first_of_value_o),
    .bad_element_o    (bad_element_o)
  );

  keyed_linked_list_table_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .cmd_i            (cmd_i),
    .element_i        (element_i),
    .value_i          (value_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .changed_i        (changed_o),
    .elem_value_i     (elem_value_o),
    .elem_next_i      (elem_next_o),
    .first_of_value_i (first_of_value_o),
    .bad_element_i    (bad_element_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input cmd_e             cmd,
                           input logic [ElemW-1:0] elem,
                           input logic [ValW-1:0]  val);
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    element_i  <= elem;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
  endtask

  // result side: random stall bursts, none once quiet
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned      issued, pick;
    cmd_e             cmd;
    logic [ElemW-1:0] elem;
    logic [ValW-1:0]  val;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_SET;
    element_i   = '0;
    value_i     = '0;
    out_ready_i = 1'b0;
    quiet       = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: null element, extremes, list edges, removal, unchanged value
    send_item(CMD_READ, 10'd0,    8'd0);
    send_item(CMD_SET,  10'd0,    8'd5);
    send_item(CMD_SET,  10'd1023, 8'd255);
    send_item(CMD_SET,  10'd1,    8'd255);
    send_item(CMD_SET,  10'd2,    8'd255);
    send_item(CMD_READ, 10'd1023, 8'd255);
    send_item(CMD_SET,  10'd1,    8'd255);
    send_item(CMD_SET,  10'd1,    8'd7);
    send_item(CMD_SET,  10'd2,    8'd7);
    send_item(CMD_SET,  10'd1023, 8'd0);
    send_item(CMD_READ, 10'd1023, 8'd255);
    send_item(CMD_READ, 10'd5,    8'd0);
    send_item(CMD_SET,  10'd9,    8'd0);
    send_item(CMD_SET,  10'd1,    8'd0);
    send_item(CMD_READ, 10'd2,    8'd7);
    send_item(CMD_SET,  10'd2,    8'd128);
    send_item(CMD_SET,  10'd512,  8'd128);
    send_item(CMD_SET,  10'd512,  8'd1);
    send_item(CMD_READ, 10'd1023, 8'd1);
    send_item(CMD_READ, 10'd0,    8'd255);
    send_item(CMD_SET,  10'd0,    8'd0);
    wait_all_results();

    issued = 0;
    while (issued < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // small pool keeps lists long, so middle unlinks happen often
        cmd  = CMD_SET;
        elem = ElemW'($urandom_range(1, 15));
        val  = ValW'($urandom_range(1, 7));
      end else if (pick < 52) begin
        cmd  = CMD_SET;
        elem = ElemW'($urandom_range(1, 15));
        val  = '0;
      end else if (pick < 75) begin
        cmd  = CMD_READ;
        elem = ElemW'($urandom_range(0, 15));
        val  = ValW'($urandom_range(0, 7));
      end else if (pick < 87) begin
        cmd  = CMD_SET;
        elem = ElemW'($urandom_range(0, 1023));
        val  = ValW'($urandom_range(0, 255));
      end else begin
        cmd  = CMD_READ;
        elem = ElemW'($urandom_range(0, 1023));
        val  = ValW'($urandom_range(0, 255));
      end
      send_item(cmd, elem, val);
      if (!(cmd == CMD_SET && elem == 0)) begin
        issued++;
      end
      if (issued == DrainAt) begin
        wait_all_results();
      end
      if (issued >= QuietFrom) begin
        quiet = 1'b1;
      end
      if (!quiet && $urandom_range(0, 7) == 0) begin
        pause_sender($urandom_range(1, 19));
      end
    end

    wait_all_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/kllt_pkg.sv
rtl/keyed_linked_list_table_top.sv
verif/keyed_linked_list_table_checker.sv
verif/keyed_linked_list_table_top_tb.sv
